// ----- src/pfk_pkg.sv -----
// Point pair feature key: shared widths, constants, types and the CORDIC
// arctangent table. Used by every module of the block.
`timescale 1ns / 1ps
`default_nettype none
package pfk_pkg;

    localparam int COORD_W         = 24;
    localparam int NORM_W          = 16;
    localparam int DIFF_W          = 25;
    localparam int SQ_W            = 50;
    localparam int LEN_W           = 25;
    localparam int DOT_W           = 42;
    localparam int MAG_W           = 41;
    localparam int DOT12_W         = 33;
    localparam int COS_W           = 16;
    localparam int COSQ_W          = 15;
    localparam int ANG_W           = 16;
    localparam int DSTEP_W         = 23;
    localparam int ASTEP_W         = 16;
    localparam int KEY_W           = 32;
    localparam int LANE_W          = 8;
    localparam int NLANES          = 4;
    localparam int APB_W           = 32;
    localparam int PADDR_W         = 3;
    localparam int SQRT_STEPS      = 25;
    localparam int ASQ_W           = 29;
    localparam int ACOS_SQRT_STEPS = 15;
    localparam int CORDIC_STEPS    = 15;
    localparam int CORDIC_GUARD    = 8;
    localparam int CORDIC_W        = 27;
    localparam int ZACC_W          = 18;
    localparam int ACOS_LAT        = 1 + ACOS_SQRT_STEPS + CORDIC_STEPS + 1;
    localparam int FRONT_STAGES    = 3;
    localparam int QDEPTH          = 4;
    localparam int ONE_Q14         = 16384;
    localparam int HALF_PI_Q14     = 25736;
    localparam int PI_Q14          = 51472;

    localparam logic [DSTEP_W-1:0] DSTEP_RESET = 23'd3277;
    localparam logic [ASTEP_W-1:0] ASTEP_RESET = 16'd1716;

    typedef enum logic [0:0] {
        REG_DIST_STEP  = 1'b0,
        REG_ANGLE_STEP = 1'b1
    } t_reg_idx;

    typedef struct packed {
        logic signed [COORD_W-1:0] ref_x;
        logic signed [COORD_W-1:0] ref_y;
        logic signed [COORD_W-1:0] ref_z;
        logic signed [NORM_W-1:0]  ref_nx;
        logic signed [NORM_W-1:0]  ref_ny;
        logic signed [NORM_W-1:0]  ref_nz;
        logic signed [COORD_W-1:0] other_x;
        logic signed [COORD_W-1:0] other_y;
        logic signed [COORD_W-1:0] other_z;
        logic signed [NORM_W-1:0]  other_nx;
        logic signed [NORM_W-1:0]  other_ny;
        logic signed [NORM_W-1:0]  other_nz;
    } t_pair_in;

    typedef struct packed {
        logic [SQ_W-1:0]           sq;
        logic signed [DOT_W-1:0]   dot1;
        logic signed [DOT_W-1:0]   dot2;
        logic signed [DOT12_W-1:0] dot12;
    } t_pair_sums;

    function automatic logic [13:0] atan_q14(input logic [3:0] idx);
        logic [13:0] v;
        unique case (idx)
            4'd0:    v = 14'd12868;
            4'd1:    v = 14'd7596;
            4'd2:    v = 14'd4014;
            4'd3:    v = 14'd2037;
            4'd4:    v = 14'd1023;
            4'd5:    v = 14'd512;
            4'd6:    v = 14'd256;
            4'd7:    v = 14'd128;
            4'd8:    v = 14'd64;
            4'd9:    v = 14'd32;
            4'd10:   v = 14'd16;
            4'd11:   v = 14'd8;
            4'd12:   v = 14'd4;
            4'd13:   v = 14'd2;
            4'd14:   v = 14'd1;
            default: v = 14'd0;
        endcase
        return v;
    endfunction

endpackage
`default_nettype wire

// ----- src/point_pair_feature_key_core.sv -----
// Channel     Signals                               Transfer
// request     start, busy, i_ref_*, i_other_*       edge with start high and busy low
// result      o_valid, o_feature_key, o_bin_*, o_*  one cycle, o_valid strobe
// registers   psel, penable, pwrite, paddr, pwdata  APB write, pready tied high
//
// One request per cycle; every stage of the sqrt, divide, CORDIC and quantise
// units is its own register, so throughput is set by nothing but the clock.
// The result strobe follows the front stages, the queue and the back-end stages.
// Reset is synchronous; no clearing pass. busy rises only when the queue and
// the front stages together could overflow, which the steady back end never lets
// happen. Results cannot be held off by the receiver.
// Depends on pfk_pkg, pfk_front, pfk_fifo, pfk_back.
`timescale 1ns / 1ps
`default_nettype none
module point_pair_feature_key_core #(
    parameter int BIN_BITS = 8
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                psel,
    input  wire logic                                penable,
    input  wire logic                                pwrite,
    input  wire logic [pfk_pkg::PADDR_W-1:0]         paddr,
    input  wire logic [pfk_pkg::APB_W-1:0]           pwdata,
    output logic [pfk_pkg::APB_W-1:0]                prdata,
    output logic                                     pready,
    input  wire logic                                start,
    output logic                                     busy,
    input  wire logic signed [pfk_pkg::COORD_W-1:0]  i_ref_x,
    input  wire logic signed [pfk_pkg::COORD_W-1:0]  i_ref_y,
    input  wire logic signed [pfk_pkg::COORD_W-1:0]  i_ref_z,
    input  wire logic signed [pfk_pkg::NORM_W-1:0]   i_ref_nx,
    input  wire logic signed [pfk_pkg::NORM_W-1:0]   i_ref_ny,
    input  wire logic signed [pfk_pkg::NORM_W-1:0]   i_ref_nz,
    input  wire logic signed [pfk_pkg::COORD_W-1:0]  i_other_x,
    input  wire logic signed [pfk_pkg::COORD_W-1:0]  i_other_y,
    input  wire logic signed [pfk_pkg::COORD_W-1:0]  i_other_z,
    input  wire logic signed [pfk_pkg::NORM_W-1:0]   i_other_nx,
    input  wire logic signed [pfk_pkg::NORM_W-1:0]   i_other_ny,
    input  wire logic signed [pfk_pkg::NORM_W-1:0]   i_other_nz,
    output logic                                     o_valid,
    output logic [pfk_pkg::KEY_W-1:0]                o_feature_key,
    output logic                                     o_bin_clipped,
    output logic                                     o_zero_length
);
    import pfk_pkg::*;

    localparam int CNT_W = $clog2(QDEPTH + 1);

    logic [DSTEP_W-1:0] r_dist_step;
    logic [ASTEP_W-1:0] r_angle_step;
    t_reg_idx           w_idx;
    logic               w_wr;
    logic               w_accept;
    t_pair_in           w_pair;
    logic               w_f_valid;
    t_pair_sums         w_f_sums;
    logic [1:0]         w_inflight;
    logic               w_q_valid;
    t_pair_sums         w_q_data;
    logic [CNT_W-1:0]   w_q_count;

    assign w_idx  = t_reg_idx'(paddr[2]);
    assign w_wr   = psel && penable && pwrite;
    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dist_step  <= DSTEP_RESET;
            r_angle_step <= ASTEP_RESET;
        end else if (w_wr) begin
            unique case (w_idx)
                REG_DIST_STEP:  r_dist_step  <= pwdata[DSTEP_W-1:0];
                REG_ANGLE_STEP: r_angle_step <= pwdata[ASTEP_W-1:0];
                default:        r_dist_step  <= r_dist_step;
            endcase
        end
    end

    always_comb begin
        unique case (w_idx)
            REG_DIST_STEP:  prdata = APB_W'(r_dist_step);
            REG_ANGLE_STEP: prdata = APB_W'(r_angle_step);
            default:        prdata = '0;
        endcase
    end

    // the head entry leaves this cycle, so it does not count against room
    assign busy     = ((CNT_W + 1)'(w_q_count) - (CNT_W + 1)'(w_q_valid)
                       + (CNT_W + 1)'(w_inflight)) >= (CNT_W + 1)'(QDEPTH);
    assign w_accept = start && !busy;

    assign w_pair.ref_x    = i_ref_x;
    assign w_pair.ref_y    = i_ref_y;
    assign w_pair.ref_z    = i_ref_z;
    assign w_pair.ref_nx   = i_ref_nx;
    assign w_pair.ref_ny   = i_ref_ny;
    assign w_pair.ref_nz   = i_ref_nz;
    assign w_pair.other_x  = i_other_x;
    assign w_pair.other_y  = i_other_y;
    assign w_pair.other_z  = i_other_z;
    assign w_pair.other_nx = i_other_nx;
    assign w_pair.other_ny = i_other_ny;
    assign w_pair.other_nz = i_other_nz;

    pfk_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_accept   (w_accept),
        .i_pair     (w_pair),
        .o_valid    (w_f_valid),
        .o_sums     (w_f_sums),
        .o_inflight (w_inflight)
    );

    pfk_fifo #(
        .DEPTH (QDEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_f_valid),
        .i_data  (w_f_sums),
        .i_pop   (w_q_valid),
        .o_valid (w_q_valid),
        .o_data  (w_q_data),
        .o_count (w_q_count)
    );

    pfk_back #(
        .BIN_BITS (BIN_BITS)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (w_q_valid),
        .i_sums        (w_q_data),
        .i_dist_step   (r_dist_step),
        .i_angle_step  (r_angle_step),
        .o_valid       (o_valid),
        .o_feature_key (o_feature_key),
        .o_bin_clipped (o_bin_clipped),
        .o_zero_length (o_zero_length)
    );

endmodule
`default_nettype wire

// ----- src/pfk_front.sv -----
// Front end: takes a point pair, forms the difference vector, the squared
// length and the three dot products in three stages. Depends on pfk_pkg.
`timescale 1ns / 1ps
`default_nettype none
module pfk_front (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_accept,
    input  wire pfk_pkg::t_pair_in   i_pair,
    output logic                     o_valid,
    output pfk_pkg::t_pair_sums      o_sums,
    output logic [1:0]               o_inflight
);
    import pfk_pkg::*;

    logic [FRONT_STAGES-1:0]        r_vld;
    logic signed [DIFF_W-1:0]       n_d [3];
    logic signed [DIFF_W-1:0]       r_d [3];
    logic signed [NORM_W-1:0]       r_n1 [3];
    logic signed [NORM_W-1:0]       r_n2 [3];
    logic [SQ_W-1:0]                r_dd [3];
    logic signed [NORM_W+DIFF_W-1:0] r_p1 [3];
    logic signed [NORM_W+DIFF_W-1:0] r_p2 [3];
    logic signed [2*NORM_W-1:0]     r_p12 [3];
    logic signed [2*DIFF_W-1:0]     n_sqp [3];
    t_pair_sums                     r_sums;

    always_comb begin
        n_d[0] = DIFF_W'(i_pair.ref_x) - DIFF_W'(i_pair.other_x);
        n_d[1] = DIFF_W'(i_pair.ref_y) - DIFF_W'(i_pair.other_y);
        n_d[2] = DIFF_W'(i_pair.ref_z) - DIFF_W'(i_pair.other_z);
        for (int k = 0; k < 3; k++) begin
            n_sqp[k] = r_d[k] * r_d[k];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[FRONT_STAGES-2:0], i_accept};
        end
        r_d     <= n_d;
        r_n1[0] <= i_pair.ref_nx;
        r_n1[1] <= i_pair.ref_ny;
        r_n1[2] <= i_pair.ref_nz;
        r_n2[0] <= i_pair.other_nx;
        r_n2[1] <= i_pair.other_ny;
        r_n2[2] <= i_pair.other_nz;
        for (int k = 0; k < 3; k++) begin
            r_dd[k]  <= SQ_W'(n_sqp[k]);
            r_p1[k]  <= r_n1[k] * r_d[k];
            r_p2[k]  <= r_n2[k] * r_d[k];
            r_p12[k] <= r_n1[k] * r_n2[k];
        end
        r_sums.sq    <= r_dd[0] + r_dd[1] + r_dd[2];
        r_sums.dot1  <= DOT_W'(r_p1[0]) + DOT_W'(r_p1[1]) + DOT_W'(r_p1[2]);
        r_sums.dot2  <= DOT_W'(r_p2[0]) + DOT_W'(r_p2[1]) + DOT_W'(r_p2[2]);
        r_sums.dot12 <= DOT12_W'(r_p12[0]) + DOT12_W'(r_p12[1]) + DOT12_W'(r_p12[2]);
    end

    assign o_valid    = r_vld[FRONT_STAGES-1];
    assign o_sums     = r_sums;
    assign o_inflight = 2'($countones(r_vld));

endmodule
`default_nettype wire

// ----- src/pfk_fifo.sv -----
// Short queue of partial sums between front and back end.
// Depends on pfk_pkg for the entry type.
`timescale 1ns / 1ps
`default_nettype none
module pfk_fifo #(
    parameter int DEPTH = 4
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_push,
    input  wire pfk_pkg::t_pair_sums  i_data,
    input  wire logic                 i_pop,
    output logic                      o_valid,
    output pfk_pkg::t_pair_sums       o_data,
    output logic [$clog2(DEPTH+1)-1:0] o_count
);
    import pfk_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_pair_sums       r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr;
    logic [PTR_W-1:0] r_rd;
    logic [CNT_W-1:0] r_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wr <= (r_wr == PTR_W'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= (r_rd == PTR_W'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (!i_push && i_pop) begin
                r_count <= r_count - 1'b1;
            end
        end
        if (i_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rd];
    assign o_count = r_count;

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_push && (r_count == CNT_W'(DEPTH))))
        else $error("queue written while full");
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> (r_count != '0))
        else $error("queue read while empty");
    a_count_up: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_push && !i_pop) |=> (r_count == $past(r_count) + 1'b1))
        else $error("queue count did not advance on push");

endmodule
`default_nettype wire

// ----- src/pfk_acos.sv -----
// Pipelined arc cosine of a Q1.14 cosine: square root for the sine, then
// CORDIC vectoring, with every root and CORDIC step registered. Depends on pfk_pkg.
`timescale 1ns / 1ps
`default_nettype none
module pfk_acos (
    input  wire logic                                i_clk,
    input  wire logic signed [pfk_pkg::COS_W-1:0]    i_cos,
    output logic [pfk_pkg::ANG_W-1:0]                o_angle
);
    import pfk_pkg::*;

    typedef struct packed {
        logic [ASQ_W-1:0]        n;
        logic [ASQ_W:0]          res;
        logic signed [COS_W-1:0] c;
    } t_as_st;

    typedef struct packed {
        logic signed [CORDIC_W-1:0] x;
        logic signed [CORDIC_W-1:0] y;
        logic signed [ZACC_W-1:0]   z;
        logic                       base;
    } t_cd_st;

    logic signed [COS_W-1:0]   r_c;
    logic [ASQ_W-1:0]          r_csq;
    logic signed [2*COS_W-1:0] w_csq;
    t_as_st                    w_as_src [ACOS_SQRT_STEPS];
    t_as_st                    n_as [ACOS_SQRT_STEPS];
    t_as_st                    r_as [ACOS_SQRT_STEPS];
    t_cd_st                    w_cd_src [CORDIC_STEPS];
    t_cd_st                    n_cd [CORDIC_STEPS];
    t_cd_st                    r_cd [CORDIC_STEPS];
    logic [ANG_W-1:0]          n_angle;
    logic [ANG_W-1:0]          r_angle;

    assign w_csq = i_cos * i_cos;

    always_comb begin
        logic [ASQ_W:0] t;
        logic [ASQ_W:0] bitv;
        w_as_src[0].n   = ASQ_W'(ONE_Q14 * ONE_Q14) - r_csq;
        w_as_src[0].res = '0;
        w_as_src[0].c   = r_c;
        for (int k = 1; k < ACOS_SQRT_STEPS; k++) begin
            w_as_src[k] = r_as[k-1];
        end
        for (int k = 0; k < ACOS_SQRT_STEPS; k++) begin
            bitv = (ASQ_W+1)'(1) << (2 * (ACOS_SQRT_STEPS - 1 - k));
            t    = w_as_src[k].res + bitv;
            n_as[k] = w_as_src[k];
            if ({1'b0, w_as_src[k].n} >= t) begin
                n_as[k].n   = w_as_src[k].n - ASQ_W'(t);
                n_as[k].res = (w_as_src[k].res >> 1) + bitv;
            end else begin
                n_as[k].res = w_as_src[k].res >> 1;
            end
        end
    end

    always_comb begin
        logic signed [CORDIC_W-1:0] s;
        logic signed [CORDIC_W-1:0] c;
        logic signed [CORDIC_W-1:0] xs;
        logic signed [CORDIC_W-1:0] ys;
        logic signed [ZACC_W-1:0]   a;
        logic signed [ZACC_W-1:0]   zf;
        s = CORDIC_W'($signed({1'b0, r_as[ACOS_SQRT_STEPS-1].res[COSQ_W-1:0]}));
        c = CORDIC_W'(r_as[ACOS_SQRT_STEPS-1].c);
        if (c < 0) begin
            w_cd_src[0].x    = s <<< CORDIC_GUARD;
            w_cd_src[0].y    = (-c) <<< CORDIC_GUARD;
            w_cd_src[0].base = 1'b1;
        end else begin
            w_cd_src[0].x    = c <<< CORDIC_GUARD;
            w_cd_src[0].y    = s <<< CORDIC_GUARD;
            w_cd_src[0].base = 1'b0;
        end
        w_cd_src[0].z = '0;
        for (int k = 1; k < CORDIC_STEPS; k++) begin
            w_cd_src[k] = r_cd[k-1];
        end
        for (int k = 0; k < CORDIC_STEPS; k++) begin
            xs = w_cd_src[k].x >>> k;
            ys = w_cd_src[k].y >>> k;
            a  = $signed(ZACC_W'(atan_q14(4'(k))));
            n_cd[k] = w_cd_src[k];
            if (w_cd_src[k].y > 0) begin
                n_cd[k].x = w_cd_src[k].x + ys;
                n_cd[k].y = w_cd_src[k].y - xs;
                n_cd[k].z = w_cd_src[k].z + a;
            end else begin
                n_cd[k].x = w_cd_src[k].x - ys;
                n_cd[k].y = w_cd_src[k].y + xs;
                n_cd[k].z = w_cd_src[k].z - a;
            end
        end
        zf = r_cd[CORDIC_STEPS-1].z
           + (r_cd[CORDIC_STEPS-1].base ? ZACC_W'(HALF_PI_Q14) : ZACC_W'(0));
        if (zf < 0) begin
            n_angle = '0;
        end else if (zf > ZACC_W'(PI_Q14)) begin
            n_angle = ANG_W'(PI_Q14);
        end else begin
            n_angle = zf[ANG_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        r_c     <= i_cos;
        r_csq   <= ASQ_W'(w_csq);
        r_as    <= n_as;
        r_cd    <= n_cd;
        r_angle <= n_angle;
    end

    assign o_angle = r_angle;

endmodule
`default_nettype wire

// ----- src/pfk_back.sv -----
// Back end: length square root, cosine divisions, three arc cosines,
// bin quantisation and key packing, one pipeline stage per step.
// Depends on pfk_pkg and pfk_acos.
`timescale 1ns / 1ps
`default_nettype none
module pfk_back #(
    parameter int BIN_BITS = 8
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_valid,
    input  wire pfk_pkg::t_pair_sums               i_sums,
    input  wire logic [pfk_pkg::DSTEP_W-1:0]       i_dist_step,
    input  wire logic [pfk_pkg::ASTEP_W-1:0]       i_angle_step,
    output logic                                   o_valid,
    output logic [pfk_pkg::KEY_W-1:0]              o_feature_key,
    output logic                                   o_bin_clipped,
    output logic                                   o_zero_length
);
    import pfk_pkg::*;

    localparam int BACK_LAT = SQRT_STEPS + 1 + COSQ_W + 1 + ACOS_LAT + 1 + BIN_BITS;
    localparam int QT_W     = DSTEP_W + BIN_BITS;
    localparam int Q12_W    = DOT12_W - 1 - 14;

    typedef struct packed {
        logic [SQ_W:0]             n;
        logic [SQ_W:0]             res;
        logic signed [DOT_W-1:0]   dot1;
        logic signed [DOT_W-1:0]   dot2;
        logic signed [DOT12_W-1:0] dot12;
    } t_sqrt_st;

    typedef struct packed {
        logic [LEN_W-1:0]        len;
        logic                    zero;
        logic [MAG_W-1:0]        rem1;
        logic [MAG_W-1:0]        rem2;
        logic                    neg1;
        logic                    neg2;
        logic                    ovf1;
        logic                    ovf2;
        logic [COSQ_W-1:0]       q1;
        logic [COSQ_W-1:0]       q2;
        logic signed [COS_W-1:0] c12;
    } t_div_st;

    typedef struct packed {
        logic [NLANES-1:0][LEN_W-1:0]    rem;
        logic [NLANES-1:0]               ovf;
        logic [NLANES-1:0][BIN_BITS-1:0] q;
        logic                            zero;
    } t_q_st;

    logic [BACK_LAT-1:0]     r_vld;
    t_sqrt_st                w_a_src [SQRT_STEPS];
    t_sqrt_st                n_a [SQRT_STEPS];
    t_sqrt_st                r_a [SQRT_STEPS];
    t_div_st                 n_b0;
    t_div_st                 r_b0;
    t_div_st                 w_b_src [COSQ_W];
    t_div_st                 n_b [COSQ_W];
    t_div_st                 r_b [COSQ_W];
    logic signed [COS_W-1:0] n_c1, n_c2;
    logic signed [COS_W-1:0] r_c1, r_c2, r_c12;
    logic [LEN_W-1:0]        r_dlen [ACOS_LAT+1];
    logic                    r_dzero [ACOS_LAT+1];
    logic [ANG_W-1:0]        w_ang [3];
    logic [DSTEP_W-1:0]      w_step [NLANES];
    t_q_st                   n_e0;
    t_q_st                   r_e0;
    t_q_st                   w_e_src [BIN_BITS];
    t_q_st                   n_e [BIN_BITS];
    t_q_st                   r_e [BIN_BITS];
    logic [KEY_W-1:0]        n_key;
    logic                    r_valid;
    logic [KEY_W-1:0]        r_key;
    logic                    r_clip;
    logic                    r_zero;

    always_comb begin
        logic [SQ_W:0] t;
        logic [SQ_W:0] bitv;
        w_a_src[0].n     = {1'b0, i_sums.sq};
        w_a_src[0].res   = '0;
        w_a_src[0].dot1  = i_sums.dot1;
        w_a_src[0].dot2  = i_sums.dot2;
        w_a_src[0].dot12 = i_sums.dot12;
        for (int k = 1; k < SQRT_STEPS; k++) begin
            w_a_src[k] = r_a[k-1];
        end
        for (int k = 0; k < SQRT_STEPS; k++) begin
            bitv = (SQ_W+1)'(1) << (2 * (SQRT_STEPS - 1 - k));
            t    = w_a_src[k].res + bitv;
            n_a[k] = w_a_src[k];
            if (w_a_src[k].n >= t) begin
                n_a[k].n   = w_a_src[k].n - t;
                n_a[k].res = (w_a_src[k].res >> 1) + bitv;
            end else begin
                n_a[k].res = w_a_src[k].res >> 1;
            end
        end
    end

    always_comb begin
        logic signed [DOT_W-1:0]   m1, m2;
        logic signed [DOT12_W-1:0] m12;
        logic [Q12_W-1:0]          q12;
        logic [COS_W-1:0]          c12m;
        t_sqrt_st                  s;
        s  = r_a[SQRT_STEPS-1];
        m1 = (s.dot1 < 0) ? -s.dot1 : s.dot1;
        m2 = (s.dot2 < 0) ? -s.dot2 : s.dot2;
        m12 = (s.dot12 < 0) ? -s.dot12 : s.dot12;
        q12 = m12[DOT12_W-2:14];
        c12m = (q12 > Q12_W'(ONE_Q14)) ? COS_W'(ONE_Q14) : COS_W'(q12);
        n_b0.len  = s.res[LEN_W-1:0];
        n_b0.zero = (s.res[LEN_W-1:0] == '0);
        n_b0.rem1 = m1[MAG_W-1:0];
        n_b0.rem2 = m2[MAG_W-1:0];
        n_b0.neg1 = (s.dot1 < 0);
        n_b0.neg2 = (s.dot2 < 0);
        n_b0.ovf1 = m1[MAG_W-1:0] >= (MAG_W'(s.res[LEN_W-1:0]) << COSQ_W);
        n_b0.ovf2 = m2[MAG_W-1:0] >= (MAG_W'(s.res[LEN_W-1:0]) << COSQ_W);
        n_b0.q1   = '0;
        n_b0.q2   = '0;
        n_b0.c12  = (s.dot12 < 0) ? -$signed(c12m) : $signed(c12m);
    end

    always_comb begin
        logic [MAG_W-1:0] t;
        w_b_src[0] = r_b0;
        for (int k = 1; k < COSQ_W; k++) begin
            w_b_src[k] = r_b[k-1];
        end
        for (int k = 0; k < COSQ_W; k++) begin
            t = MAG_W'(w_b_src[k].len) << (COSQ_W - 1 - k);
            n_b[k] = w_b_src[k];
            if (w_b_src[k].rem1 >= t) begin
                n_b[k].rem1 = w_b_src[k].rem1 - t;
                n_b[k].q1[COSQ_W-1-k] = 1'b1;
            end
            if (w_b_src[k].rem2 >= t) begin
                n_b[k].rem2 = w_b_src[k].rem2 - t;
                n_b[k].q2[COSQ_W-1-k] = 1'b1;
            end
        end
    end

    always_comb begin
        logic [COS_W-1:0] m1, m2;
        t_div_st          s;
        s  = r_b[COSQ_W-1];
        m1 = (s.ovf1 || s.q1 > COSQ_W'(ONE_Q14)) ? COS_W'(ONE_Q14) : COS_W'(s.q1);
        m2 = (s.ovf2 || s.q2 > COSQ_W'(ONE_Q14)) ? COS_W'(ONE_Q14) : COS_W'(s.q2);
        if (s.zero) begin
            n_c1 = '0;
            n_c2 = '0;
        end else begin
            n_c1 = s.neg1 ? -$signed(m1) : $signed(m1);
            n_c2 = s.neg2 ? -$signed(m2) : $signed(m2);
        end
    end

    pfk_acos u_acos_n1d  (.i_clk(i_clk), .i_cos(r_c1),  .o_angle(w_ang[0]));
    pfk_acos u_acos_n2d  (.i_clk(i_clk), .i_cos(r_c2),  .o_angle(w_ang[1]));
    pfk_acos u_acos_n1n2 (.i_clk(i_clk), .i_cos(r_c12), .o_angle(w_ang[2]));

    always_comb begin
        logic [LEN_W-1:0] v;
        w_step[0] = (i_dist_step == '0) ? DSTEP_W'(1) : i_dist_step;
        for (int l = 1; l < NLANES; l++) begin
            w_step[l] = (i_angle_step == '0) ? DSTEP_W'(1) : DSTEP_W'(i_angle_step);
        end
        n_e0.zero = r_dzero[ACOS_LAT];
        n_e0.q    = '0;
        for (int l = 0; l < NLANES; l++) begin
            v = (l == 0) ? r_dlen[ACOS_LAT] : LEN_W'(w_ang[(l == 0) ? 0 : l - 1]);
            n_e0.rem[l] = v;
            n_e0.ovf[l] = QT_W'(v >> BIN_BITS) >= QT_W'(w_step[l]);
        end
    end

    always_comb begin
        logic [QT_W-1:0] t;
        w_e_src[0] = r_e0;
        for (int k = 1; k < BIN_BITS; k++) begin
            w_e_src[k] = r_e[k-1];
        end
        for (int k = 0; k < BIN_BITS; k++) begin
            n_e[k] = w_e_src[k];
            for (int l = 0; l < NLANES; l++) begin
                t = QT_W'(w_step[l]) << (BIN_BITS - 1 - k);
                if (QT_W'(w_e_src[k].rem[l]) >= t) begin
                    n_e[k].rem[l] = w_e_src[k].rem[l] - t[LEN_W-1:0];
                    n_e[k].q[l][BIN_BITS-1-k] = 1'b1;
                end
            end
        end
    end

    always_comb begin
        n_key = '0;
        for (int l = 0; l < NLANES; l++) begin
            n_key[l*LANE_W +: LANE_W] = r_e[BIN_BITS-1].ovf[l]
                ? LANE_W'({BIN_BITS{1'b1}}) : LANE_W'(r_e[BIN_BITS-1].q[l]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld   <= '0;
            r_valid <= 1'b0;
        end else begin
            r_vld   <= {r_vld[BACK_LAT-2:0], i_valid};
            r_valid <= r_vld[BACK_LAT-1];
        end
        r_a   <= n_a;
        r_b0  <= n_b0;
        r_b   <= n_b;
        r_c1  <= n_c1;
        r_c2  <= n_c2;
        r_c12 <= r_b[COSQ_W-1].c12;
        r_dlen[0]  <= r_b[COSQ_W-1].len;
        r_dzero[0] <= r_b[COSQ_W-1].zero;
        for (int k = 1; k < ACOS_LAT + 1; k++) begin
            r_dlen[k]  <= r_dlen[k-1];
            r_dzero[k] <= r_dzero[k-1];
        end
        r_e0   <= n_e0;
        r_e    <= n_e;
        r_key  <= n_key;
        r_clip <= |r_e[BIN_BITS-1].ovf;
        r_zero <= r_e[BIN_BITS-1].zero;
    end

    assign o_valid       = r_valid;
    assign o_feature_key = r_key;
    assign o_bin_clipped = r_clip;
    assign o_zero_length = r_zero;

    a_zero_dist_bin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && r_zero) |-> (r_key[LANE_W-1:0] == '0))
        else $error("coinciding points gave a nonzero distance bin");
    a_clip_saturates: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && r_clip) |->
            (r_key[LANE_W-1:0] == LANE_W'({BIN_BITS{1'b1}}))
            || (r_key[2*LANE_W-1:LANE_W] == LANE_W'({BIN_BITS{1'b1}}))
            || (r_key[3*LANE_W-1:2*LANE_W] == LANE_W'({BIN_BITS{1'b1}}))
            || (r_key[4*LANE_W-1:3*LANE_W] == LANE_W'({BIN_BITS{1'b1}})))
        else $error("clip flag without a saturated bin");

endmodule
`default_nettype wire

// ----- sim/testbench.sv -----
// Testbench for point_pair_feature_key_core: drives pair requests and APB
// register writes, predicts each feature key in fixed point, and checks results.
// Depends on pfk_pkg and the point_pair_feature_key_core RTL.
`timescale 1ns / 1ps
`default_nettype none
module testbench;
    import pfk_pkg::*;

    localparam int BIN_MAX = 255;
    localparam int LATENCY = 88;
    localparam int WATCHDOG_LIMIT = 4000;

    typedef struct packed {
        logic [KEY_W-1:0] key;
        logic             clipped;
        logic             zero_len;
    } t_key_result;

    class key_scoreboard;
        t_key_result pending[$];
        int          errors;
        longint      dist_step;
        longint      ang_step;

        function void set_steps(longint ds, longint as_);
            dist_step = ds;
            ang_step  = as_;
        endfunction

        function longint isqrt(longint n);
            longint r;
            longint b;
            r = 0;
            b = 64'sd1 <<< 62;
            while (b > n) b = b >>> 2;
            while (b != 0) begin
                if (n >= r + b) begin
                    n = n - (r + b);
                    r = (r >>> 1) + b;
                end else begin
                    r = r >>> 1;
                end
                b = b >>> 2;
            end
            return r;
        endfunction

        function longint fshift(longint v, int s);
            if (v >= 0) return v >>> s;
            return -(((-v) - 1) >>> s) - 1;
        endfunction

        function longint div_toward_zero(longint num, longint den);
            longint m;
            m = (num < 0) ? -num : num;
            m = m / den;
            return (num < 0) ? -m : m;
        endfunction

        function longint clamp_unit(longint c);
            if (c > ONE_Q14) return ONE_Q14;
            if (c < -ONE_Q14) return -ONE_Q14;
            return c;
        endfunction

        function longint arc_cos(longint c);
            longint s, x, y, z, base, xs, ys;
            longint atan_lut[CORDIC_STEPS];
            atan_lut = '{12868, 7596, 4014, 2037, 1023, 512, 256, 128, 64, 32, 16, 8,
                         4, 2, 1};
            s = isqrt(longint'(ONE_Q14) * ONE_Q14 - c * c);
            z = 0;
            base = 0;
            if (c < 0) begin
                x = s;
                y = -c;
                base = HALF_PI_Q14;
            end else begin
                x = c;
                y = s;
            end
            x = x * 256;
            y = y * 256;
            for (int i = 0; i < CORDIC_STEPS; i++) begin
                xs = fshift(x, i);
                ys = fshift(y, i);
                if (y > 0) begin
                    x = x + ys;
                    y = y - xs;
                    z = z + atan_lut[i];
                end else begin
                    x = x - ys;
                    y = y + xs;
                    z = z - atan_lut[i];
                end
            end
            z = z + base;
            if (z < 0) z = 0;
            if (z > PI_Q14) z = PI_Q14;
            return z;
        endfunction

        function longint bin_of(longint v, longint stp, inout bit clip);
            longint q;
            q = v / ((stp == 0) ? 1 : stp);
            if (q > BIN_MAX) begin
                q = BIN_MAX;
                clip = 1;
            end
            return q;
        endfunction

        function void note_request(t_pair_in p);
            longint d[3], n1[3], n2[3];
            longint sq, dot1, dot2, dot12, len, c1, c2, c12, bd, b1, b2, b12;
            bit clip;
            t_key_result r;
            d[0] = longint'(p.ref_x) - longint'(p.other_x);
            d[1] = longint'(p.ref_y) - longint'(p.other_y);
            d[2] = longint'(p.ref_z) - longint'(p.other_z);
            n1 = '{longint'(p.ref_nx), longint'(p.ref_ny), longint'(p.ref_nz)};
            n2 = '{longint'(p.other_nx), longint'(p.other_ny), longint'(p.other_nz)};
            sq = 0; dot1 = 0; dot2 = 0; dot12 = 0;
            for (int k = 0; k < 3; k++) begin
                sq = sq + d[k] * d[k];
                dot1 = dot1 + n1[k] * d[k];
                dot2 = dot2 + n2[k] * d[k];
                dot12 = dot12 + n1[k] * n2[k];
            end
            len = isqrt(sq);
            c1 = 0;
            c2 = 0;
            if (len != 0) begin
                c1 = clamp_unit(div_toward_zero(dot1, len));
                c2 = clamp_unit(div_toward_zero(dot2, len));
            end
            c12 = clamp_unit(div_toward_zero(dot12, ONE_Q14));
            clip = 0;
            bd  = bin_of(len, dist_step, clip);
            b1  = bin_of(arc_cos(c1), ang_step, clip);
            b2  = bin_of(arc_cos(c2), ang_step, clip);
            b12 = bin_of(arc_cos(c12), ang_step, clip);
            r.key = {b12[7:0], b2[7:0], b1[7:0], bd[7:0]};
            r.clipped = clip;
            r.zero_len = (len == 0);
            pending.push_back(r);
        endfunction

        function void check_result(t_key_result got);
            t_key_result exp_r;
            if (pending.size() == 0) begin
                errors++;
                if (errors <= 10) $display("unexpected result key=%h", got.key);
                return;
            end
            exp_r = pending.pop_front();
            if (got !== exp_r) begin
                errors++;
                if (errors <= 10)
                    $display("mismatch: exp key=%h clip=%b zero=%b got key=%h clip=%b zero=%b",
                             exp_r.key, exp_r.clipped, exp_r.zero_len,
                             got.key, got.clipped, got.zero_len);
            end
        endfunction
    endclass

    logic i_clk, i_rst_n;
    logic psel, penable, pwrite;
    logic [PADDR_W-1:0] paddr;
    logic [APB_W-1:0] pwdata, prdata;
    logic pready, start, busy;
    t_pair_in pair;
    logic o_valid, o_bin_clipped, o_zero_length;
    logic [KEY_W-1:0] o_feature_key;

    key_scoreboard sb;
    int idle_pct;
    int stall_cycles;

    point_pair_feature_key_core u_top (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready),
        .start(start), .busy(busy),
        .i_ref_x(pair.ref_x), .i_ref_y(pair.ref_y), .i_ref_z(pair.ref_z),
        .i_ref_nx(pair.ref_nx), .i_ref_ny(pair.ref_ny), .i_ref_nz(pair.ref_nz),
        .i_other_x(pair.other_x), .i_other_y(pair.other_y), .i_other_z(pair.other_z),
        .i_other_nx(pair.other_nx), .i_other_ny(pair.other_ny),
        .i_other_nz(pair.other_nz),
        .o_valid(o_valid), .o_feature_key(o_feature_key),
        .o_bin_clipped(o_bin_clipped), .o_zero_length(o_zero_length)
    );

    initial begin
        i_clk = 0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        if (i_rst_n && start && !busy) sb.note_request(pair);
        if (i_rst_n && o_valid) sb.check_result({o_feature_key, o_bin_clipped, o_zero_length});
        if (!i_rst_n || (start && !busy) || o_valid) stall_cycles <= 0;
        else stall_cycles <= stall_cycles + 1;
    end

    always @(posedge i_clk) begin
        if (stall_cycles >= WATCHDOG_LIMIT) begin
            $display("FAIL point_pair_feature_key_core");
            $finish;
        end
    end

    task automatic write_reg(t_reg_idx idx, logic [APB_W-1:0] val);
        psel <= 1;
        penable <= 0;
        pwrite <= 1;
        paddr <= PADDR_W'(idx) << 2;
        pwdata <= val;
        @(posedge i_clk);
        penable <= 1;
        @(posedge i_clk);
        psel <= 0;
        penable <= 0;
        pwrite <= 0;
        @(posedge i_clk);
        if (idx == REG_DIST_STEP) sb.dist_step = val[DSTEP_W-1:0];
        else sb.ang_step = val[ASTEP_W-1:0];
    endtask

    task automatic send_pair(t_pair_in p);
        while ($urandom_range(99) < idle_pct) begin
            start <= 0;
            @(posedge i_clk);
        end
        start <= 1;
        pair <= p;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
    endtask

    task automatic drain();
        int guard;
        guard = 0;
        start <= 0;
        while (sb.pending.size() != 0 && guard < 20 * LATENCY) begin
            @(posedge i_clk);
            guard++;
        end
        repeat (LATENCY / 4) @(posedge i_clk);
    endtask

    function automatic logic signed [NORM_W-1:0] rand_norm(int mode);
        if (mode == 0) return NORM_W'($urandom_range(32768) - 16384);
        return NORM_W'($urandom);
    endfunction

    function automatic t_pair_in rand_pair();
        t_pair_in p;
        int m;
        int span;
        m = $urandom_range(9);
        span = (m < 3) ? 300000 : ((m < 6) ? 5000 : 8388607);
        p.ref_x = COORD_W'($urandom);
        p.ref_y = COORD_W'($urandom);
        p.ref_z = COORD_W'($urandom);
        if (m == 9) begin
            p.other_x = COORD_W'($urandom);
            p.other_y = COORD_W'($urandom);
            p.other_z = COORD_W'($urandom);
        end else begin
            p.other_x = p.ref_x + COORD_W'($urandom_range(2 * span) - span);
            p.other_y = p.ref_y + COORD_W'($urandom_range(2 * span) - span);
            p.other_z = p.ref_z + COORD_W'($urandom_range(2 * span) - span);
            if ($urandom_range(30) == 0) {p.other_x, p.other_y, p.other_z} =
                {p.ref_x, p.ref_y, p.ref_z};
        end
        p.ref_nx = rand_norm(m == 8); p.ref_ny = rand_norm(m == 8);
        p.ref_nz = rand_norm(m == 8);
        p.other_nx = rand_norm(m == 7); p.other_ny = rand_norm(m == 7);
        p.other_nz = rand_norm(m == 7);
        return p;
    endfunction

    task automatic directed_pairs();
        t_pair_in p;
        p = '0;
        p.ref_nx = 16384; p.other_nx = 16384; p.ref_x = 65536;
        send_pair(p);
        p.other_nx = -16384;
        send_pair(p);
        p.ref_x = 0;
        send_pair(p);
        p = '0;
        p.ref_x = 24'sh7FFFFF; p.ref_y = 24'sh7FFFFF; p.ref_z = 24'sh7FFFFF;
        p.other_x = 24'sh800000; p.other_y = 24'sh800000; p.other_z = 24'sh800000;
        p.ref_nx = 16384; p.ref_ny = -16384; p.ref_nz = 16384;
        p.other_nx = -16384; p.other_ny = -16384; p.other_nz = -16384;
        send_pair(p);
        p.ref_nx = 16'sh7FFF; p.ref_ny = 16'sh7FFF; p.ref_nz = 16'sh7FFF;
        p.other_nx = 16'sh8000; p.other_ny = 16'sh8000; p.other_nz = 16'sh8000;
        send_pair(p);
        p.ref_nx = 16'sh8000; p.other_nx = 16'sh8000;
        send_pair(p);
        p = '0;
        p.ref_y = 1; p.ref_ny = 16384; p.other_nz = 16384;
        send_pair(p);
        p.ref_y = -1; p.ref_ny = 11585; p.ref_nz = 11585;
        send_pair(p);
        repeat (6) send_pair(rand_pair());
    endtask

    task automatic random_phase(int count);
        for (int i = 0; i < count; i++) send_pair(rand_pair());
    endtask

    initial begin
        sb = new();
        sb.set_steps(DSTEP_RESET, ASTEP_RESET);
        i_rst_n = 0;
        psel = 0; penable = 0; pwrite = 0; paddr = '0; pwdata = '0;
        start = 0;
        pair = '0;
        idle_pct = 0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        directed_pairs();
        drain();
        write_reg(REG_DIST_STEP, 1);
        write_reg(REG_ANGLE_STEP, 1);
        directed_pairs();
        drain();
        write_reg(REG_DIST_STEP, 23'h7FFFFF);
        write_reg(REG_ANGLE_STEP, 16'hFFFF);
        directed_pairs();
        drain();
        write_reg(REG_DIST_STEP, 0);
        write_reg(REG_ANGLE_STEP, 0);
        random_phase(40);
        drain();

        idle_pct = 36;
        write_reg(REG_DIST_STEP, 30000);
        write_reg(REG_ANGLE_STEP, 500);
        random_phase(250);
        drain();
        idle_pct = 52;
        write_reg(REG_DIST_STEP, DSTEP_RESET);
        write_reg(REG_ANGLE_STEP, ASTEP_RESET);
        random_phase(250);
        drain();
        idle_pct = 0;
        write_reg(REG_DIST_STEP, $urandom_range(8388607, 1));
        write_reg(REG_ANGLE_STEP, $urandom_range(65535, 1));
        random_phase(250);
        drain();

        if (sb.errors == 0 && sb.pending.size() == 0) begin
            $display("PASS point_pair_feature_key_core");
        end else begin
            $display("FAIL point_pair_feature_key_core");
        end
        $finish;
    end
endmodule
`default_nettype wire

// ----- files.f -----
src/pfk_pkg.sv
src/pfk_front.sv
src/pfk_fifo.sv
src/pfk_acos.sv
src/pfk_back.sv
src/point_pair_feature_key_core.sv
sim/testbench.sv
